>>> src/cabd_pkg.sv
`default_nettype none
package cabd_pkg;

  localparam int BACKLOG_BITS = 20;
  localparam int CMD_BITS     = 15;
  localparam int MAG_BITS     = 14;
  localparam int PERIOD_BITS  = 16;
  localparam int PULSE_BITS   = 8;
  localparam int DRIVE_BITS   = 3;
  localparam int IN_BITS      = 48;
  localparam int OUT_BITS     = 56;
  localparam int OUT_USED     = 52;

  localparam logic CFG_BURST_PERIOD = 1'b0;
  localparam logic CFG_MAX_PULSES   = 1'b1;

  localparam logic [PERIOD_BITS-1:0] BURST_PERIOD_RESET = 16'd6400;
  localparam logic [PULSE_BITS-1:0]  MAX_PULSES_RESET   = 8'd24;

  typedef logic signed [BACKLOG_BITS-1:0] backlog_t;

  typedef struct packed {
    logic                write;
    logic [CMD_BITS-1:0] pulse;
  } axis_res_t;

endpackage
`default_nettype wire

>>> src/cabd_timer.sv
`default_nettype none
module cabd_timer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             advance,
  input  wire logic [cabd_pkg::DRIVE_BITS-1:0]  drive_bits,
  input  wire logic [cabd_pkg::PERIOD_BITS-1:0] burst_period,
  output logic                                  fire
);
  import cabd_pkg::*;

  logic [PERIOD_BITS-1:0] elapsed;
  logic [PERIOD_BITS-1:0] elapsed_next;
  logic                   prev_active;
  logic                   active;
  logic [PERIOD_BITS:0]   inc;
  logic [PERIOD_BITS-1:0] inc_sat;

  always_comb begin
    active  = |drive_bits;
    inc     = {1'b0, elapsed} + {{PERIOD_BITS{1'b0}}, 1'b1};
    inc_sat = inc[PERIOD_BITS] ? {PERIOD_BITS{1'b1}} : inc[PERIOD_BITS-1:0];
    fire         = 1'b0;
    elapsed_next = '0;
    if (active) begin
      if (!prev_active) begin
        fire = 1'b1;
      end else if (inc_sat >= burst_period) begin
        fire = 1'b1;
      end else begin
        elapsed_next = inc_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed     <= '0;
      prev_active <= 1'b0;
    end else if (advance) begin
      elapsed     <= elapsed_next;
      prev_active <= active;
    end
  end
endmodule
`default_nettype wire

>>> src/cabd_axis.sv
`default_nettype none
module cabd_axis (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            advance,
  input  wire logic                            fire,
  input  wire logic                            en,
  input  wire logic [cabd_pkg::CMD_BITS-1:0]   cmd,
  input  wire logic [cabd_pkg::PULSE_BITS-1:0] max_pulses,
  output cabd_pkg::axis_res_t                  res
);
  import cabd_pkg::*;

  backlog_t                  backlog;
  backlog_t                  backlog_next;
  logic signed [BACKLOG_BITS:0] addend;
  logic signed [BACKLOG_BITS:0] sum;
  backlog_t                  b;
  logic                      neg;
  logic [BACKLOG_BITS-1:0]   mag;
  logic [BACKLOG_BITS-1:0]   mag_left;
  logic [PULSE_BITS-1:0]     delta;

  always_comb begin
    if (cmd[CMD_BITS-1]) begin
      addend = -$signed({{(BACKLOG_BITS+1-MAG_BITS){1'b0}}, ~cmd[MAG_BITS-1:0]});
    end else begin
      addend = $signed({{(BACKLOG_BITS+1-MAG_BITS){1'b0}}, cmd[MAG_BITS-1:0]});
    end
    sum = {backlog[BACKLOG_BITS-1], backlog} + addend;
    if (!en) begin
      b = backlog;
    end else if (sum[BACKLOG_BITS] != sum[BACKLOG_BITS-1]) begin
      b = sum[BACKLOG_BITS] ? {1'b1, {(BACKLOG_BITS-1){1'b0}}}
                            : {1'b0, {(BACKLOG_BITS-1){1'b1}}};
    end else begin
      b = sum[BACKLOG_BITS-1:0];
    end
    neg = b[BACKLOG_BITS-1];
    mag = neg ? BACKLOG_BITS'(-b) : BACKLOG_BITS'(b);
    if (mag >= {{(BACKLOG_BITS-PULSE_BITS){1'b0}}, max_pulses}) begin
      delta = max_pulses;
    end else begin
      delta = mag[PULSE_BITS-1:0];
    end
    mag_left     = mag - {{(BACKLOG_BITS-PULSE_BITS){1'b0}}, delta};
    backlog_next = neg ? backlog_t'(-mag_left) : backlog_t'(mag_left);
    res.write = fire && (delta != '0);
    res.pulse = res.write
              ? {neg, {(CMD_BITS-1-PULSE_BITS){1'b0}}, delta} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      backlog <= '0;
    end else if (advance && fire) begin
      backlog <= backlog_next;
    end
  end
endmodule
`default_nettype wire

>>> src/coarse_align_burst_driver.sv
`default_nettype none
// Coarse-alignment burst driver. One request on s_axis is one drive tick and
// always yields exactly one request on m_axis, in order. A burst fires on the
// tick where any drive enable comes on from all-off, then every burst_period
// ticks while any enable stays on; on a burst each enabled axis folds its
// ones'-complement command into a saturating signed backlog, and every axis
// emits a sign-magnitude pulse word of at most max_pulses from its backlog.
// Non-burst ticks give an all-zero result. Throughput is one tick per clock
// while m_axis_tready does not stall the output; a tick passes the input
// register, then the result register, with the backlog and timer state closing their loop between the two.
// Configuration writes are always accepted and must be made while idle.
module coarse_align_burst_driver (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // drive_bits[2:0], cmd_x[17:3], cmd_y[32:18], cmd_z[47:33]
  input  wire logic [cabd_pkg::IN_BITS-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // burst_fired[0], clear_x[1], clear_y[2], clear_z[3], write_x[4],
  // pulse_x[19:5], write_y[20], pulse_y[35:21], write_z[36], pulse_z[51:37]
  output logic [cabd_pkg::OUT_BITS-1:0]      m_axis_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import cabd_pkg::*;

  logic [PERIOD_BITS-1:0] burst_period;
  logic [PULSE_BITS-1:0]  max_pulses;
  logic                   in_valid;
  logic [IN_BITS-1:0]     in_data;
  logic                   advance;
  logic                   fire;
  logic [DRIVE_BITS-1:0]  drive;
  axis_res_t              res_x;
  axis_res_t              res_y;
  axis_res_t              res_z;
  logic [OUT_USED-1:0]    result;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign drive         = in_data[DRIVE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_period <= BURST_PERIOD_RESET;
      max_pulses   <= MAX_PULSES_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BURST_PERIOD: burst_period <= cfg_data;
        CFG_MAX_PULSES:   max_pulses   <= cfg_data[PULSE_BITS-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
    end
  end

  cabd_timer u_timer (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .drive_bits   (drive),
    .burst_period (burst_period),
    .fire         (fire)
  );

  cabd_axis u_axis_x (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .fire       (fire),
    .en         (drive[2]),
    .cmd        (in_data[17:3]),
    .max_pulses (max_pulses),
    .res        (res_x)
  );

  cabd_axis u_axis_y (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .fire       (fire),
    .en         (drive[1]),
    .cmd        (in_data[32:18]),
    .max_pulses (max_pulses),
    .res        (res_y)
  );

  cabd_axis u_axis_z (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .fire       (fire),
    .en         (drive[0]),
    .cmd        (in_data[47:33]),
    .max_pulses (max_pulses),
    .res        (res_z)
  );

  assign result = {res_z.pulse, res_z.write, res_y.pulse, res_y.write,
                   res_x.pulse, res_x.write,
                   fire & drive[0], fire & drive[1], fire & drive[2], fire};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {{(OUT_BITS-OUT_USED){1'b0}}, result};
    end
  end
endmodule
`default_nettype wire
